>>> hdl/jep_pkg.sv
// ----------------------------------------------------------------------------
// jep_pkg: shared types and constants of the Julia escape-time pixel block
// Register indexes, reset values, pixel codes, sequencer states and the
// control bundle of the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package jep_pkg;

	// Fixed field widths
	localparam int ITER_WIDTH      = 16;
	localparam int RADIUS_WIDTH    = 47;
	localparam int PIXEL_WIDTH     = 8;
	localparam int CFG_INDEX_WIDTH = 3;

	// Register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_C_REAL         = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_C_IMAG         = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEFT_EDGE      = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOP_EDGE       = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRID_STEP      = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ITERATION_CAP  = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIUS_SQUARED = 3'd6;

	// Reset values
	localparam logic [ITER_WIDTH-1:0]   ITER_CAP_RESET = 16'd200;
	localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET   = 47'd671088640000;

	// Pixel codes
	localparam logic [PIXEL_WIDTH-1:0] PIX_ESCAPED = 8'd0;
	localparam logic [PIXEL_WIDTH-1:0] PIX_BOUNDED = 8'd255;

	// Multiplier step counter: four partial products, one drain, one finish
	localparam int                 MUL_CNT_WIDTH = 3;
	localparam logic [MUL_CNT_WIDTH-1:0] MUL_LAST_STEP = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GRID_COL,
		ST_GRID_ROW,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_CHECK,
		ST_CROSS,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;       // launch a product
		logic frac_shift;  // shift the product right by the fraction bits
		logic a_raw;       // operand a is an unsigned index, not two's complement
	} mul_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/jep_mul.sv
// ----------------------------------------------------------------------------
// jep_mul: shared saturating fixed-point multiplier
// Sign-magnitude product built from four half-width partial products, then
// shifted, saturated and given its sign.
// ----------------------------------------------------------------------------
`default_nettype none

module jep_mul #(
	parameter int VALUE_WIDTH   = 48,
	parameter int FRACTION_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  jep_pkg::mul_ctrl_t            ctrl,
	input  logic signed [VALUE_WIDTH-1:0] op_a,
	input  logic signed [VALUE_WIDTH-1:0] op_b,
	output logic                          done,
	output logic signed [VALUE_WIDTH-1:0] result
);
	import jep_pkg::*;

	localparam int W    = VALUE_WIDTH;
	localparam int HALF = (W + 1) / 2;
	localparam int AW   = 2 * W;
	localparam int PP_W = 2 * HALF;

	logic                     busy_q;
	logic [MUL_CNT_WIDTH-1:0] cnt_q;
	logic                     neg_q;
	logic                     frac_q;
	logic [W-1:0]             ma_q;
	logic [W-1:0]             mb_q;
	logic [PP_W-1:0]          pp_s1;
	logic [1:0]               pp_idx_s1;
	logic                     pp_vld_s1;
	logic [AW-1:0]            acc_q;
	logic                     done_q;
	logic signed [W-1:0]      result_q;

	logic                     a_neg;
	logic [W-1:0]             ma_d;
	logic [W-1:0]             mb_d;
	logic [HALF-1:0]          oa;
	logic [HALF-1:0]          ob;
	logic [PP_W-1:0]          pp;
	logic [AW-1:0]            acc_add;
	logic [AW-1:0]            shifted;
	logic [AW-1:0]            lim;
	logic [W-1:0]             mag;
	logic signed [W-1:0]      res_d;

	// Operand magnitudes
	always_comb begin
		a_neg = !ctrl.a_raw && op_a[W-1];
		ma_d  = a_neg ? W'(-op_a) : W'(op_a);
		mb_d  = op_b[W-1] ? W'(-op_b) : W'(op_b);
	end

	// Partial product: bit 1 of the step picks the upper half of a, bit 0 of b
	always_comb begin
		oa = cnt_q[1] ? HALF'(ma_q[W-1:HALF]) : ma_q[HALF-1:0];
		ob = cnt_q[0] ? HALF'(mb_q[W-1:HALF]) : mb_q[HALF-1:0];
		pp = oa * ob;
	end

	always_comb begin
		unique case (pp_idx_s1)
			2'd0:    acc_add = AW'(pp_s1);
			2'd3:    acc_add = AW'(pp_s1) << (2 * HALF);
			default: acc_add = AW'(pp_s1) << HALF;
		endcase
	end

	// Shift, saturate, apply sign
	always_comb begin
		shifted = frac_q ? (acc_q >> FRACTION_BITS) : acc_q;
		lim     = neg_q ? (AW'(1) << (W - 1)) : ((AW'(1) << (W - 1)) - AW'(1));
		mag     = (shifted > lim) ? lim[W-1:0] : shifted[W-1:0];
		res_d   = neg_q ? signed'(W'(-mag)) : signed'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			pp_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			pp_vld_s1 <= busy_q && !cnt_q[2];
			if (ctrl.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pp_s1     <= pp;
		pp_idx_s1 <= cnt_q[1:0];
		if (ctrl.start && !busy_q) begin
			ma_q   <= ma_d;
			mb_q   <= mb_d;
			neg_q  <= a_neg ^ op_b[W-1];
			frac_q <= ctrl.frac_shift;
			acc_q  <= '0;
		end else if (pp_vld_s1) begin
			acc_q <= acc_q + acc_add;
		end
		if (busy_q && cnt_q == MUL_LAST_STEP) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

>>> hdl/julia_escape_pixel_top.sv
// ----------------------------------------------------------------------------
// julia_escape_pixel_top: Julia set escape-time test of one pixel
// Maps a pixel's column and row to a start point and iterates z = z*z + c in
// saturating fixed point until the point escapes or the iteration cap runs out.
// ----------------------------------------------------------------------------
// One pixel at a time. A pixel is taken on in_valid/in_ready, and in_ready
// stays low until its result is loaded into the output register. Every
// product goes through one shared multiplier that builds it from four
// half-width partial products plus drain, saturate and hand-back steps. For a
// pixel, two products form the start point, two squares give |z|^2, and each
// of the n iterations run (at most iteration_cap) takes the cross term, an
// update state and the two new squares, which serve both the escape test and
// the next iteration. The result pixel_value is 0 when the point escaped,
// 255 when it stayed bounded. A finished result sits in an output register,
// so the next pixel is taken while the previous transaction still waits for
// out_ready. Configuration writes are always taken (cfg_ready is tied high)
// and must only happen while the block is idle; writes to an unknown index
// are dropped.
`default_nettype none

module julia_escape_pixel_top #(
	parameter int  INDEX_WIDTH   = 16,
	parameter int  VALUE_WIDTH   = 48,
	parameter int  FRACTION_BITS = 24,
	localparam int CFG_WIDTH     = (VALUE_WIDTH > jep_pkg::RADIUS_WIDTH) ?
	                               VALUE_WIDTH : jep_pkg::RADIUS_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [jep_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [CFG_WIDTH-1:0]                 cfg_data,
	// pixel input channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [INDEX_WIDTH-1:0]               column,
	input  logic [INDEX_WIDTH-1:0]               row,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [jep_pkg::PIXEL_WIDTH-1:0]      pixel_value
);
	import jep_pkg::*;

	localparam int W = VALUE_WIDTH;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};

	// Saturating add and subtract in the working format
	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
	                                                input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			return s[W] ? MINV : MAXV;
		end
		return s[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
	                                                input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) begin
			return s[W] ? MINV : MAXV;
		end
		return s[W-1:0];
	endfunction

	// Configuration registers
	logic signed [W-1:0]     c_real_q;
	logic signed [W-1:0]     c_imag_q;
	logic signed [W-1:0]     left_q;
	logic signed [W-1:0]     top_q;
	logic signed [W-1:0]     step_q;
	logic [ITER_WIDTH-1:0]   cap_q;
	logic [RADIUS_WIDTH-1:0] rad_q;

	// Sequencer and datapath
	state_t                  state_q;
	state_t                  state_d;
	logic                    issued_q;
	logic [INDEX_WIDTH-1:0]  col_q;
	logic [INDEX_WIDTH-1:0]  row_q;
	logic signed [W-1:0]     re_q;
	logic signed [W-1:0]     im_q;
	logic signed [W-1:0]     rr_q;
	logic signed [W-1:0]     ii_q;
	logic signed [W-1:0]     ri_q;
	logic [ITER_WIDTH-1:0]   n_q;
	logic                    esc_q;
	logic                    out_valid_q;
	logic [PIXEL_WIDTH-1:0]  pixel_q;

	// Shared multiplier
	mul_ctrl_t               mul_ctrl;
	logic signed [W-1:0]     mul_a;
	logic signed [W-1:0]     mul_b;
	logic                    mul_done;
	logic signed [W-1:0]     mul_res;
	logic                    mul_state;

	// Escape test
	logic [W-1:0]            mag_sum;
	logic [W-1:0]            mag_d;
	logic                    escaped;
	logic                    finish;

	jep_mul #(
		.VALUE_WIDTH   (VALUE_WIDTH),
		.FRACTION_BITS (FRACTION_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mul_ctrl),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	// |z|^2 from the squares; both are never negative, so only the top clamp applies
	always_comb begin
		mag_sum = W'(rr_q) + W'(ii_q);
		mag_d   = mag_sum[W-1] ? W'(MAXV) : mag_sum;
		escaped = CFG_WIDTH'(mag_d) > CFG_WIDTH'(rad_q);
		// stop at the cap; the escape test is ignored before the first iteration
		finish  = (n_q == cap_q) || ((n_q != '0) && escaped);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_GRID_COL;
			ST_GRID_COL: if (mul_done) state_d = ST_GRID_ROW;
			ST_GRID_ROW: if (mul_done) state_d = ST_SQ_RE;
			ST_SQ_RE:    if (mul_done) state_d = ST_SQ_IM;
			ST_SQ_IM:    if (mul_done) state_d = ST_CHECK;
			ST_CHECK:    state_d = finish ? ST_DONE : ST_CROSS;
			ST_CROSS:    if (mul_done) state_d = ST_UPDATE;
			ST_UPDATE:   state_d = ST_SQ_RE;
			ST_DONE:     if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: operand routing and multiplier launch
	always_comb begin
		mul_state           = 1'b0;
		mul_a               = re_q;
		mul_b               = re_q;
		mul_ctrl.frac_shift = 1'b1;
		mul_ctrl.a_raw      = 1'b0;
		unique case (state_q)
			ST_GRID_COL: begin
				mul_state           = 1'b1;
				mul_a               = W'(col_q);
				mul_b               = step_q;
				mul_ctrl.frac_shift = 1'b0;
				mul_ctrl.a_raw      = 1'b1;
			end
			ST_GRID_ROW: begin
				mul_state           = 1'b1;
				mul_a               = W'(row_q);
				mul_b               = step_q;
				mul_ctrl.frac_shift = 1'b0;
				mul_ctrl.a_raw      = 1'b1;
			end
			ST_SQ_RE: begin
				mul_state = 1'b1;
			end
			ST_SQ_IM: begin
				mul_state = 1'b1;
				mul_a     = im_q;
				mul_b     = im_q;
			end
			ST_CROSS: begin
				mul_state = 1'b1;
				mul_a     = im_q;
			end
			default: begin
				mul_state = 1'b0;
			end
		endcase
		mul_ctrl.start = mul_state && !issued_q;
		in_ready       = (state_q == ST_IDLE);
	end

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_q;

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q <= '0;
			c_imag_q <= '0;
			left_q   <= '0;
			top_q    <= '0;
			step_q   <= '0;
			cap_q    <= ITER_CAP_RESET;
			rad_q    <= RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_C_REAL:         c_real_q <= cfg_data[W-1:0];
				REG_C_IMAG:         c_imag_q <= cfg_data[W-1:0];
				REG_LEFT_EDGE:      left_q   <= cfg_data[W-1:0];
				REG_TOP_EDGE:       top_q    <= cfg_data[W-1:0];
				REG_GRID_STEP:      step_q   <= cfg_data[W-1:0];
				REG_ITERATION_CAP:  cap_q    <= cfg_data[ITER_WIDTH-1:0];
				REG_RADIUS_SQUARED: rad_q    <= cfg_data[RADIUS_WIDTH-1:0];
				default:            ;
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_ctrl.start) begin
				issued_q <= 1'b1;
			end else if (mul_done) begin
				issued_q <= 1'b0;
			end
			// retire the waiting transaction, then load the new one
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					col_q <= column;
					row_q <= row;
					n_q   <= '0;
				end
			end
			ST_GRID_COL: if (mul_done) re_q <= sat_add(left_q, mul_res);
			ST_GRID_ROW: if (mul_done) im_q <= sat_sub(top_q, mul_res);
			ST_SQ_RE:    if (mul_done) rr_q <= mul_res;
			ST_SQ_IM:    if (mul_done) ii_q <= mul_res;
			ST_CHECK:    esc_q <= escaped;
			ST_CROSS:    if (mul_done) ri_q <= mul_res;
			ST_UPDATE: begin
				re_q <= sat_add(sat_sub(rr_q, ii_q), c_real_q);
				im_q <= sat_add(sat_add(ri_q, ri_q), c_imag_q);
				n_q  <= n_q + 1'b1;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					pixel_q <= esc_q ? PIX_ESCAPED : PIX_BOUNDED;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
